// File: rtl/core/lpm_pkg.sv
// shared types, codes and helpers of the longest prefix match router
`default_nettype none

package lpm_pkg;

  // request kinds on the input channel
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_ROUTE = 1'b1;

  localparam logic [31:0] LPM_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [5:0]  LPM_MAX_LEN  = 6'd32;

  // result status codes
  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_FORWARDED = 3'd2,
    ST_EXPIRED   = 3'd3,
    ST_NO_ROUTE  = 3'd4
  } lpm_status_t;

  // request travelling along the row of cells
  // for an add, dest and the best_* fields carry the new route itself
  typedef struct packed {
    logic          valid;
    logic          write;
    logic          search;
    logic          found;
    lpm_status_t   status;
    logic [31:0]   dest;
    logic [7:0]    ttl;
    logic [5:0]    best_len;
    logic [2:0]    best_ifc;
    logic          best_hop_valid;
    logic [31:0]   best_hop_ip;
  } lpm_req_t;

  // leading ones mask of a saturated prefix length
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    len_mask = ~(LPM_ALL_ONES >> len);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lpm_in_if.sv
// input channel: route add and datagram lookup requests
`default_nettype none

interface lpm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] route_pfx;
  logic [5:0]  pfx_len;
  logic        hop_valid;
  logic [31:0] hop_ip;
  logic [2:0]  interface_index;
  logic [31:0] dest_ip;
  logic [7:0]  ttl;

  modport source (
    output valid, kind, route_pfx, pfx_len, hop_valid,
           hop_ip, interface_index, dest_ip, ttl,
    input  ready
  );
  modport sink (
    input  valid, kind, route_pfx, pfx_len, hop_valid,
           hop_ip, interface_index, dest_ip, ttl,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/lpm_out_if.sv
// result channel: one status record per request
`default_nettype none

interface lpm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  out_interface;
  logic [31:0] hop_addr;
  logic [7:0]  ttl_out;

  modport source (
    output valid, status, out_interface, hop_addr, ttl_out,
    input  ready
  );
  modport sink (
    input  valid, status, out_interface, hop_addr, ttl_out,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/lpm_cell.sv
// one route slot of the table and one stage of the request row
`default_nettype none

module lpm_cell
  import lpm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned CELL_INDEX  = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire lpm_req_t                              req_i,
  input  wire logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] slot_i,
  input  wire logic [$clog2(TABLE_DEPTH + 1)-1:0]    count_i,
  output lpm_req_t                                   req_o,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] slot_o,
  output logic [$clog2(TABLE_DEPTH + 1)-1:0]         count_o
);

  localparam int unsigned SLOT_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(TABLE_DEPTH + 1);

  // stored route, undefined until its add passes by
  logic [31:0] pfx_r;
  logic [5:0]  len_r;
  logic        hopv_r;
  logic [31:0] hopip_r;
  logic [2:0]  ifc_r;

  lpm_req_t           req_r;
  lpm_req_t           req_nxt;
  logic [SLOT_W-1:0]  slot_r;
  logic [COUNT_W-1:0] count_r;

  logic in_table;
  logic match;
  logic better;
  logic take_write;

  // the route here counts only if it was added before this request entered
  assign in_table   = count_i > COUNT_W'(CELL_INDEX);
  assign match      = ((req_i.dest ^ pfx_r) & len_mask(len_r)) == 32'd0;
  assign better     = !req_i.found || (len_r > req_i.best_len);
  assign take_write = en && req_i.valid && req_i.write && (slot_i == SLOT_W'(CELL_INDEX));

  // candidate update as the lookup passes
  always_comb begin
    req_nxt = req_i;
    if (req_i.search && in_table && match && better) begin
      req_nxt.found          = 1'b1;
      req_nxt.best_len       = len_r;
      req_nxt.best_ifc       = ifc_r;
      req_nxt.best_hop_valid = hopv_r;
      req_nxt.best_hop_ip    = hopip_r;
    end
  end

  // route storage
  always_ff @(posedge clk) begin
    if (take_write) begin
      pfx_r   <= req_i.dest;
      len_r   <= req_i.best_len;
      hopv_r  <= req_i.best_hop_valid;
      hopip_r <= req_i.best_hop_ip;
      ifc_r   <= req_i.best_ifc;
    end
  end

  // stage register towards the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else if (en) begin
      req_r   <= req_nxt;
      slot_r  <= slot_i;
      count_r <= count_i;
    end
  end

  assign req_o   = req_r;
  assign slot_o  = slot_r;
  assign count_o = count_r;

endmodule

`default_nettype wire

// File: rtl/core/longest_prefix_match_router_core.sv
// top level: request entry, row of route cells and result register
//
//   channel   direction  handshake     payload
//   in_req    in         valid/ready   kind, route fields, dest_ip, ttl
//   out_res   out        valid/ready   status, out_interface, hop_addr, ttl_out
//
// one request enters per cycle while the row advances; its result is registered
// after it has passed through the stage register of every cell in the row, in
// order from the first cell to the last, and then through the result register
// reset clears the route count and the valid flags; a cell is read only once
// an add has filled it
// while the result register is full and not taken, the whole row holds still
// and in_req.ready is low
`default_nettype none

module longest_prefix_match_router_core
  import lpm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH     = 64,
  parameter int unsigned INTERFACE_COUNT = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpm_in_if.sink     in_req,
  lpm_out_if.source  out_res
);

  localparam int unsigned SLOT_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(TABLE_DEPTH + 1);

  logic               en;
  logic               accept;
  logic               full;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [5:0]         sat_len;
  logic [2:0]         ifc_tab [8];
  lpm_req_t           entry;

  lpm_req_t           req_chain   [TABLE_DEPTH + 1];
  logic [SLOT_W-1:0]  slot_chain  [TABLE_DEPTH + 1];
  logic [COUNT_W-1:0] count_chain [TABLE_DEPTH + 1];

  lpm_req_t           last;
  logic               fwd;

  logic               out_valid_r;
  logic [2:0]         status_r;
  logic [2:0]         oif_r;
  logic [31:0]        nh_r;
  logic [7:0]         ttl_r;

  // row advances whenever the result register can take what leaves it
  assign en           = !out_valid_r || out_res.ready;
  assign in_req.ready = en;
  assign accept       = in_req.valid && en;
  assign full         = count_r == COUNT_W'(TABLE_DEPTH);

  // interface index reduced to the configured interface count
  for (genvar k = 0; k < 8; k++) begin : g_ifc
    localparam int unsigned IFC_RED = k % INTERFACE_COUNT;
    assign ifc_tab[k] = 3'(IFC_RED);
  end

  assign sat_len = (in_req.pfx_len > LPM_MAX_LEN) ? LPM_MAX_LEN
                                                  : in_req.pfx_len;

  // request as it enters the first cell
  always_comb begin
    entry       = '0;
    entry.valid = in_req.valid;
    if (in_req.kind == KIND_ADD) begin
      entry.write          = !full;
      entry.status         = full ? ST_FULL : ST_ADDED;
      entry.dest           = in_req.route_pfx;
      entry.best_len       = sat_len;
      entry.best_ifc       = ifc_tab[in_req.interface_index];
      entry.best_hop_valid = in_req.hop_valid;
      entry.best_hop_ip    = in_req.hop_ip;
    end else begin
      entry.search = in_req.ttl > 8'd1;
      entry.status = (in_req.ttl > 8'd1) ? ST_NO_ROUTE : ST_EXPIRED;
      entry.dest   = in_req.dest_ip;
      entry.ttl    = in_req.ttl;
    end
  end

  // route count: the slot the next add fills
  always_comb begin
    count_nxt = count_r;
    if (accept && (in_req.kind == KIND_ADD) && !full) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign req_chain[0]   = entry;
  assign slot_chain[0]  = count_r[SLOT_W-1:0];
  assign count_chain[0] = count_r;

  // row of route cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lpm_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .req_i   (req_chain[i]),
      .slot_i  (slot_chain[i]),
      .count_i (count_chain[i]),
      .req_o   (req_chain[i + 1]),
      .slot_o  (slot_chain[i + 1]),
      .count_o (count_chain[i + 1])
    );
  end

  assign last = req_chain[TABLE_DEPTH];
  assign fwd  = last.search && last.found;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
      status_r    <= fwd ? ST_FORWARDED : last.status;
      oif_r       <= fwd ? last.best_ifc : 3'd0;
      nh_r        <= fwd ? (last.best_hop_valid ? last.best_hop_ip : last.dest) : 32'd0;
      ttl_r       <= fwd ? 8'(last.ttl - 8'd1) : 8'd0;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = status_r;
  assign out_res.out_interface = oif_r;
  assign out_res.hop_addr      = nh_r;
  assign out_res.ttl_out       = ttl_r;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the longest prefix match router core: directed and random adds and lookups
`default_nettype none

module testbench;
  import lpm_pkg::*;

  localparam int unsigned ROUTE_SLOTS  = 64;
  localparam int unsigned IFC_COUNT    = 8;
  localparam int unsigned RANDOM_ITEMS = 630;

  // one request as the input channel carries it
  typedef struct {
    logic        kind;
    logic [31:0] route_pfx;
    logic [5:0]  pfx_len;
    logic        hop_valid;
    logic [31:0] hop_ip;
    logic [2:0]  interface_index;
    logic [31:0] dest_ip;
    logic [7:0]  ttl;
  } lpm_request_t;

  // one status record as the result channel carries it
  typedef struct {
    lpm_status_t status;
    logic [2:0]  out_interface;
    logic [31:0] hop_addr;
    logic [7:0]  ttl_out;
  } lpm_result_t;

  // routing table shadow and queue of pending status records
  class route_scoreboard;
    logic [31:0] prefix_of    [ROUTE_SLOTS];
    logic [5:0]  len_of       [ROUTE_SLOTS];
    logic        hop_valid_of [ROUTE_SLOTS];
    logic [31:0] hop_ip_of    [ROUTE_SLOTS];
    logic [2:0]  ifc_of       [ROUTE_SLOTS];
    int unsigned routes_held;
    lpm_result_t pending_results[$];
    int unsigned mismatches;

    function new();
      routes_held = 0;
      mismatches  = 0;
    endfunction

    // leading ones over a prefix length, lengths past 32 saturated
    static function logic [31:0] prefix_mask(input logic [5:0] len);
      logic [5:0] sat;
      sat = (len > LPM_MAX_LEN) ? LPM_MAX_LEN : len;
      prefix_mask = (sat == 6'd0) ? 32'd0 : (LPM_ALL_ONES << (6'd32 - sat));
    endfunction

    function int unsigned pending();
      pending = pending_results.size();
    endfunction

    // work out the status record of an accepted request, updating the table on adds
    function void note_request(input lpm_request_t rq);
      lpm_result_t r;
      logic [31:0] m;
      logic [5:0]  best_len;
      int          best;
      r.status        = ST_ADDED;
      r.out_interface = 3'd0;
      r.hop_addr      = 32'd0;
      r.ttl_out       = 8'd0;
      best_len        = 6'd0;
      best            = -1;
      if (rq.kind == KIND_ADD) begin
        if (routes_held >= ROUTE_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          prefix_of[routes_held]    = rq.route_pfx;
          len_of[routes_held]       = (rq.pfx_len > LPM_MAX_LEN) ? LPM_MAX_LEN
                                                                 : rq.pfx_len;
          hop_valid_of[routes_held] = rq.hop_valid;
          hop_ip_of[routes_held]    = rq.hop_ip;
          ifc_of[routes_held]       = 3'(rq.interface_index % IFC_COUNT);
          routes_held++;
        end
      end else if (rq.ttl <= 8'd1) begin
        r.status = ST_EXPIRED;
      end else begin
        // strictly longer wins, so the earliest of equal lengths stays
        for (int i = 0; i < int'(routes_held); i++) begin
          m = prefix_mask(len_of[i]);
          if ((rq.dest_ip & m) == (prefix_of[i] & m) &&
              (best < 0 || len_of[i] > best_len)) begin
            best     = i;
            best_len = len_of[i];
          end
        end
        if (best < 0) begin
          r.status = ST_NO_ROUTE;
        end else begin
          r.status        = ST_FORWARDED;
          r.out_interface = ifc_of[best];
          r.hop_addr      = hop_valid_of[best] ? hop_ip_of[best] : rq.dest_ip;
          r.ttl_out       = rq.ttl - 8'd1;
        end
      end
      pending_results.insert(pending_results.size(), r);
    endfunction

    // compare a delivered record with the oldest pending one
    function void check_result(input lpm_result_t got);
      lpm_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d ifc %0d hop %h ttl %0d",
                   got.status, got.out_interface, got.hop_addr, got.ttl_out);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.out_interface !== want.out_interface ||
          got.hop_addr !== want.hop_addr || got.ttl_out !== want.ttl_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected status %0d ifc %0d hop %h ttl %0d,",
                    " got status %0d ifc %0d hop %h ttl %0d"},
                   want.status, want.out_interface, want.hop_addr, want.ttl_out,
                   got.status, got.out_interface, got.hop_addr, got.ttl_out);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lpm_in_if  req_ch ();
  lpm_out_if res_ch ();

  longest_prefix_match_router_core #(
    .TABLE_DEPTH     (ROUTE_SLOTS),
    .INTERFACE_COUNT (IFC_COUNT)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  route_scoreboard sb = new();
  lpm_request_t    stim_q[$];
  logic [31:0]     made_prefix_q[$];
  logic [5:0]      made_len_q[$];
  int unsigned     results_taken = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a request with noise in every field it does not use
  function automatic lpm_request_t noisy_request(input logic kind);
    lpm_request_t rq;
    rq.kind            = kind;
    rq.route_pfx       = $urandom;
    rq.pfx_len         = 6'($urandom_range(0, 63));
    rq.hop_valid       = 1'($urandom_range(0, 1));
    rq.hop_ip          = $urandom;
    rq.interface_index = 3'($urandom_range(0, 7));
    rq.dest_ip         = $urandom;
    rq.ttl             = 8'($urandom_range(0, 255));
    return rq;
  endfunction

  task automatic queue_add(input logic [31:0] pfx, input logic [5:0] len, input logic hv,
                           input logic [31:0] hop, input logic [2:0] ifc);
    lpm_request_t rq;
    rq                 = noisy_request(KIND_ADD);
    rq.route_pfx       = pfx;
    rq.pfx_len         = len;
    rq.hop_valid       = hv;
    rq.hop_ip          = hop;
    rq.interface_index = ifc;
    stim_q.insert(stim_q.size(), rq);
    made_prefix_q.insert(made_prefix_q.size(), pfx);
    made_len_q.insert(made_len_q.size(), len);
  endtask

  task automatic queue_lookup(input logic [31:0] dest, input logic [7:0] ttl);
    lpm_request_t rq;
    rq         = noisy_request(KIND_ROUTE);
    rq.dest_ip = dest;
    rq.ttl     = ttl;
    stim_q.insert(stim_q.size(), rq);
  endtask

  // directed corners, then random adds and lookups aimed mostly at stored routes
  task automatic build_stimulus();
    logic [31:0] base, m, pfx;
    logic [5:0]  len;
    logic [7:0]  ttl;
    int          j, held, pick;
    // empty table and expiry
    queue_lookup(32'h0A01_0203, 8'd64);
    queue_lookup(32'h0A01_0203, 8'd0);
    queue_lookup(32'h0A01_0203, 8'd1);
    // nested routes, host bits in a prefix, an oversize length, an equal length tie
    queue_add(32'h0A00_0000, 6'd8,  1'b1, 32'hC0A8_0001, 3'd1);
    queue_add(32'h0A01_0000, 6'd16, 1'b0, 32'h1234_5678, 3'd2);
    queue_add(32'h0A01_02FF, 6'd24, 1'b1, 32'hC0A8_0002, 3'd3);
    queue_add(32'h0A01_0203, 6'd40, 1'b1, 32'hFFFF_FFFF, 3'd7);
    queue_add(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0009, 3'd5);
    queue_add(32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0000_0000, 3'd6);
    queue_add(32'h0000_0000, 6'd32, 1'b0, 32'hFFFF_FFFF, 3'd4);
    queue_lookup(32'h0A01_0203, 8'd255);
    queue_lookup(32'h0A01_0204, 8'd2);
    queue_lookup(32'h0A01_FFFF, 8'd128);
    queue_lookup(32'h0AFF_FFFF, 8'd3);
    queue_lookup(32'h0B00_0000, 8'd64);
    queue_lookup(32'hFFFF_FFFF, 8'd255);
    queue_lookup(32'h0000_0000, 8'd2);
    queue_lookup(32'h0A01_0203, 8'd1);
    queue_lookup(32'h8000_0000, 8'd200);

    for (int k = 0; k < int'(RANDOM_ITEMS); k++) begin
      held = (made_prefix_q.size() < ROUTE_SLOTS) ? made_prefix_q.size() : ROUTE_SLOTS;
      if ($urandom_range(0, 99) < 12) begin
        // default route kept late so that misses are seen for most of the run
        if (made_prefix_q.size() == 58) begin
          len = 6'd0;
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 2)       len = 6'($urandom_range(1, 7));
          else if (pick < 8)  len = 6'($urandom_range(8, 32));
          else if (pick == 8) len = 6'd32;
          else                len = 6'($urandom_range(33, 63));
        end
        pfx = $urandom;
        // often a refinement or an equal length twin of a stored route
        if (held > 0 && len != 6'd0 && $urandom_range(0, 99) < 60) begin
          j    = $urandom_range(0, held - 1);
          base = made_prefix_q[j];
          if ($urandom_range(0, 1) == 1) len = made_len_q[j];
          m    = route_scoreboard::prefix_mask(made_len_q[j]);
          pfx  = (base & m) | (pfx & ~m);
        end
        queue_add(pfx, len, 1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10)      ttl = 8'($urandom_range(0, 1));
        else if (pick < 15) ttl = 8'd255;
        else if (pick < 20) ttl = 8'd2;
        else                ttl = 8'($urandom_range(2, 254));
        base = $urandom;
        if (held > 0 && $urandom_range(0, 99) < 65) begin
          j    = $urandom_range(0, held - 1);
          m    = route_scoreboard::prefix_mask(made_len_q[j]);
          base = (made_prefix_q[j] & m) | (base & ~m);
        end
        queue_lookup(base, ttl);
      end
    end
  endtask

  // sender: bursts of requests with random gaps between them
  task automatic send_requests();
    int burst_left, gap;
    burst_left = 0;
    while (stim_q.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      req_ch.valid           <= 1'b1;
      req_ch.kind            <= stim_q[0].kind;
      req_ch.route_pfx       <= stim_q[0].route_pfx;
      req_ch.pfx_len         <= stim_q[0].pfx_len;
      req_ch.hop_valid       <= stim_q[0].hop_valid;
      req_ch.hop_ip          <= stim_q[0].hop_ip;
      req_ch.interface_index <= stim_q[0].interface_index;
      req_ch.dest_ip         <= stim_q[0].dest_ip;
      req_ch.ttl             <= stim_q[0].ttl;
      do @(posedge clk); while (req_ch.ready !== 1'b1);
      void'(stim_q.pop_front());
      burst_left--;
    end
    req_ch.valid <= 1'b0;
  endtask

  // receiver: stall patterns of random length, plus one long hold-off
  initial begin : result_taker
    int style, span;
    bit held_off;
    held_off     = 1'b0;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 160);
      for (int c = 0; c < span; c++) begin
        @(posedge clk);
        if (!held_off && results_taken >= 150) begin
          held_off = 1'b1;
          res_ch.ready <= 1'b0;
          repeat (400) @(posedge clk);
        end
        case (style)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ((c % 3) != 0);
        endcase
      end
    end
  end

  // watch both channels; requests are noted before results are checked
  always @(posedge clk) begin
    lpm_request_t rq;
    lpm_result_t  rs;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        rq.kind            = req_ch.kind;
        rq.route_pfx       = req_ch.route_pfx;
        rq.pfx_len         = req_ch.pfx_len;
        rq.hop_valid       = req_ch.hop_valid;
        rq.hop_ip          = req_ch.hop_ip;
        rq.interface_index = req_ch.interface_index;
        rq.dest_ip         = req_ch.dest_ip;
        rq.ttl             = req_ch.ttl;
        sb.note_request(rq);
      end
      if (res_ch.valid && res_ch.ready) begin
        rs.status        = lpm_status_t'(res_ch.status);
        rs.out_interface = res_ch.out_interface;
        rs.hop_addr      = res_ch.hop_addr;
        rs.ttl_out       = res_ch.ttl_out;
        sb.check_result(rs);
        results_taken++;
      end
    end
  end

  // main sequence: reset, send, drain, verdict
  initial begin
    rst_n                  = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.kind            = KIND_ADD;
    req_ch.route_pfx       = 32'd0;
    req_ch.pfx_len         = 6'd0;
    req_ch.hop_valid       = 1'b0;
    req_ch.hop_ip          = 32'd0;
    req_ch.interface_index = 3'd0;
    req_ch.dest_ip         = 32'd0;
    req_ch.ttl             = 8'd0;
    build_stimulus();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_requests();
    while (sb.pending() != 0) @(posedge clk);
    repeat (ROUTE_SLOTS + 16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
